[rtl/xrr_pkg.sv]
// Shared types and constants for the ranged xorshift128 random block.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package xrr_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned CNT_W  = $clog2(WORD_W);

  // Generator seed words loaded at reset.
  localparam logic [WORD_W-1:0] SEED_A = 32'd123456789;
  localparam logic [WORD_W-1:0] SEED_B = 32'd362436069;
  localparam logic [WORD_W-1:0] SEED_C = 32'd521288629;
  localparam logic [WORD_W-1:0] SEED_D = 32'd932288624;

  // Shift amounts of one xorshift128 step.
  localparam int unsigned SHIFT_A_LEFT  = 11;
  localparam int unsigned SHIFT_D_RIGHT = 19;
  localparam int unsigned SHIFT_T_RIGHT = 8;

  typedef enum logic [1:0] {
    MOD_IDLE,
    MOD_RUN,
    MOD_DONE
  } mod_state_t;

  // Control from the top level into the serial modulo unit.
  typedef struct packed {
    logic start;
    logic ack;
  } mod_ctrl_t;

  // Status from the serial modulo unit back to the top level.
  typedef struct packed {
    logic idle;
    logic done;
  } mod_stat_t;

endpackage

[rtl/xorshift128_ranged_random.sv]
// Top level of the ranged random-number block: stream ports, request and
// result registers. Depends on xrr_pkg, xrr_gen and xrr_mod.
`timescale 1ns / 1ps

// Usage
// Each transaction on the in_ channel is one request carrying a signed lower
// and upper bound. It advances a xorshift128 generator by one step and yields
// one transaction on the out_ channel: the new 32-bit generator word (raw_draw,
// also a 0.32 unsigned fraction) and that word reduced modulo the unsigned span
// (range_to - range_from + 1) and offset by range_from, wrapping mod 2^32.
// When the span wraps to zero the reduction is skipped.
// The reduction is a restoring remainder unit that consumes one dividend bit
// per cycle. The unit loads at the edge of the input transaction, takes one
// bit step for each of the 32 dividend bits and then the final add into the
// output register. The unit goes back to idle at the edge of that add and
// can then take the next request. A request with a full span skips the bit
// steps and goes straight to the final add. in_tready is high only while
// that unit is idle, so one request is in work at a time.
// Reset (rst_n low, synchronous) reloads the four seed words and empties the
// unit and the output register. The output register holds a finished result
// while out_tready is low; the unit may already take the next request and
// then waits with its own result until the output register is free.
module xorshift128_ranged_random (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] range_from, [63:32] range_to
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata   // [31:0] ranged_value, [63:32] raw_draw
);
  import xrr_pkg::*;

  logic [WORD_W-1:0] range_from_w;
  logic [WORD_W-1:0] range_to_w;
  logic [WORD_W-1:0] span_w;
  logic [WORD_W-1:0] draw_w;
  logic [WORD_W-1:0] rem_w;
  logic              in_acc_w;
  logic              load_out_w;
  mod_ctrl_t         mod_ctrl;
  mod_stat_t         mod_stat;

  // Request fields kept while the remainder is being formed.
  logic [WORD_W-1:0] from_r;
  logic [WORD_W-1:0] raw_r;

  logic              out_valid_r;
  logic [WORD_W-1:0] ranged_r;
  logic [WORD_W-1:0] raw_out_r;

  assign range_from_w = in_tdata[WORD_W-1:0];
  assign range_to_w   = in_tdata[2*WORD_W-1:WORD_W];

  // Span wraps mod 2^32; zero stands for the full range.
  assign span_w = range_to_w - range_from_w + 1'b1;

  assign in_tready  = mod_stat.idle;
  assign in_acc_w   = in_tvalid && in_tready;
  assign load_out_w = mod_stat.done && (!out_valid_r || out_tready);

  always_comb begin
    mod_ctrl.start = in_acc_w;
    mod_ctrl.ack   = load_out_w;
  end

  xrr_gen u_gen (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (in_acc_w),
    .draw  (draw_w)
  );

  xrr_mod u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (mod_ctrl),
    .dividend  (draw_w),
    .divisor   (span_w),
    .stat      (mod_stat),
    .remainder (rem_w)
  );

  always_ff @(posedge clk) begin
    if (in_acc_w) begin
      from_r <= range_from_w;
      raw_r  <= draw_w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out_w) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out_w) begin
      ranged_r  <= rem_w + from_r;
      raw_out_r <= raw_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {raw_out_r, ranged_r};

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc_w |=> !in_tready)
    else $error("request taken while the previous one is still in work");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    load_out_w |=> out_tvalid)
    else $error("finished result was not presented");

  a_hold_unit: assert property (@(posedge clk) disable iff (!rst_n)
    (mod_stat.done && out_valid_r && !out_tready) |=> mod_stat.done)
    else $error("result dropped while the output register was full");

endmodule

[rtl/xrr_gen.sv]
// Four-word xorshift128 generator state with a one-step advance.
// Depends on xrr_pkg for the word width, seeds and shift amounts.
`timescale 1ns / 1ps

module xrr_gen (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step,
  output logic [xrr_pkg::WORD_W-1:0] draw
);
  import xrr_pkg::*;

  logic [WORD_W-1:0] a_r, b_r, c_r, d_r;
  logic [WORD_W-1:0] t_w;
  logic [WORD_W-1:0] d_nxt;

  always_comb begin
    t_w   = a_r ^ (a_r << SHIFT_A_LEFT);
    d_nxt = d_r ^ (d_r >> SHIFT_D_RIGHT) ^ t_w ^ (t_w >> SHIFT_T_RIGHT);
  end

  // The word the next step will produce.
  assign draw = d_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r <= SEED_A;
      b_r <= SEED_B;
      c_r <= SEED_C;
      d_r <= SEED_D;
    end else if (step) begin
      a_r <= b_r;
      b_r <= c_r;
      c_r <= d_r;
      d_r <= d_nxt;
    end
  end

endmodule

[rtl/xrr_mod.sv]
// Bit-serial restoring modulo unit: one dividend bit per cycle.
// Depends on xrr_pkg for the word width, state type and control structs.
`timescale 1ns / 1ps

module xrr_mod (
  input  logic                       clk,
  input  logic                       rst_n,
  input  xrr_pkg::mod_ctrl_t         ctrl,
  input  logic [xrr_pkg::WORD_W-1:0] dividend,
  input  logic [xrr_pkg::WORD_W-1:0] divisor,
  output xrr_pkg::mod_stat_t         stat,
  output logic [xrr_pkg::WORD_W-1:0] remainder
);
  import xrr_pkg::*;

  mod_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic [WORD_W-1:0] rem_r;
  logic [WORD_W-1:0] quo_r;
  logic [WORD_W-1:0] div_r;
  logic [WORD_W:0]   trial_w;
  logic              fits_w;
  logic [WORD_W-1:0] rem_step_w;

  // One restoring step: bring in the next dividend bit, subtract if it fits.
  always_comb begin
    trial_w    = {rem_r, quo_r[WORD_W-1]};
    fits_w     = (trial_w >= {1'b0, div_r});
    rem_step_w = fits_w ? trial_w[WORD_W-1:0] - div_r : trial_w[WORD_W-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      MOD_IDLE: begin
        if (ctrl.start) begin
          state_nxt = (divisor == '0) ? MOD_DONE : MOD_RUN;
        end
      end
      MOD_RUN: begin
        if (cnt_r == '0) begin
          state_nxt = MOD_DONE;
        end
      end
      MOD_DONE: begin
        if (ctrl.ack) begin
          state_nxt = MOD_IDLE;
        end
      end
      default: state_nxt = MOD_IDLE;
    endcase
  end

  always_comb begin
    stat.idle = (state_r == MOD_IDLE);
    stat.done = (state_r == MOD_DONE);
  end

  assign remainder = rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MOD_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == MOD_IDLE && ctrl.start) begin
        cnt_r <= CNT_W'(WORD_W - 1);
      end else if (state_r == MOD_RUN) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == MOD_IDLE && ctrl.start) begin
      div_r <= divisor;
      quo_r <= dividend;
      // A zero divisor means the full 2^32 span: the draw is its own remainder.
      rem_r <= (divisor == '0) ? dividend : '0;
    end else if (state_r == MOD_RUN) begin
      rem_r <= rem_step_w;
      quo_r <= {quo_r[WORD_W-2:0], 1'b0};
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.start |-> state_r == MOD_IDLE)
    else $error("modulo unit started while busy");

  a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == MOD_RUN && cnt_r == '0) |=> state_r == MOD_DONE)
    else $error("modulo unit did not finish after the last bit");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (stat.done && div_r != '0) |-> rem_r < div_r)
    else $error("remainder not below the divisor");

endmodule

[tb/xorshift128_ranged_random_tb.sv]
// Self-checking testbench for the ranged xorshift128 random block.
// Depends on xrr_pkg and xorshift128_ranged_random; a scoreboard class tracks the generator.
`timescale 1ns / 1ps

// Expected content of one out_ transaction.
typedef struct packed {
  logic        [31:0] raw_draw;
  logic signed [31:0] ranged_value;
} draw_result_t;

// Shadow copy of the generator plus the FIFO of results still owed by the block.
class ranged_draw_scoreboard;
  logic [31:0]  gen_a, gen_b, gen_c, gen_d;
  draw_result_t owed_q[$];
  int unsigned  noted, checked, full_spans, mismatches;

  function new();
    gen_a      = xrr_pkg::SEED_A;
    gen_b      = xrr_pkg::SEED_B;
    gen_c      = xrr_pkg::SEED_C;
    gen_d      = xrr_pkg::SEED_D;
    noted      = 0;
    checked    = 0;
    full_spans = 0;
    mismatches = 0;
  endfunction

  // One xorshift128 step; the new fourth word is the draw.
  function logic [31:0] step_generator();
    logic [31:0] t;
    logic [31:0] d;
    t     = gen_a ^ (gen_a << xrr_pkg::SHIFT_A_LEFT);
    d     = gen_d;
    gen_a = gen_b;
    gen_b = gen_c;
    gen_c = d;
    gen_d = d ^ (d >> xrr_pkg::SHIFT_D_RIGHT) ^ t ^ (t >> xrr_pkg::SHIFT_T_RIGHT);
    return gen_d;
  endfunction

  function void note_request(logic [31:0] range_from, logic [31:0] range_to);
    logic [31:0]  span;
    logic [31:0]  draw;
    logic [31:0]  offset;
    draw_result_t owed;
    span = range_to - range_from + 32'd1;
    draw = step_generator();
    // A span that wraps to zero means the whole 32-bit range: no reduction.
    if (span == 32'd0) begin
      offset = draw;
      full_spans++;
    end else begin
      offset = draw % span;
    end
    owed.raw_draw     = draw;
    owed.ranged_value = offset + range_from;
    owed_q.push_back(owed);
    noted++;
  endfunction

  function int unsigned pending();
    return owed_q.size();
  endfunction

  task report_mismatch(string what);
    mismatches++;
    if (mismatches <= 40) begin
      $display("[%0t] MISMATCH: %s", $time, what);
    end
  endtask

  task check_result(logic [63:0] tdata);
    draw_result_t owed;
    logic signed [31:0] got_ranged;
    logic        [31:0] got_raw;
    got_ranged = tdata[31:0];
    got_raw    = tdata[63:32];
    if (owed_q.size() == 0) begin
      report_mismatch($sformatf("result %h arrived with nothing outstanding", tdata));
      return;
    end
    owed = owed_q.pop_front();
    checked++;
    if (got_raw !== owed.raw_draw) begin
      report_mismatch($sformatf("result %0d raw_draw %h, wanted %h",
                                checked, got_raw, owed.raw_draw));
    end
    if (got_ranged !== owed.ranged_value) begin
      report_mismatch($sformatf("result %0d ranged_value %h, wanted %h",
                                checked, got_ranged, owed.ranged_value));
    end
  endtask
endclass

module xorshift128_ranged_random_tb;

  localparam int unsigned RANDOM_ITEMS  = 1600;
  localparam int unsigned LONG_HOLD     = 400;  // cycles the receiver refuses results
  localparam int unsigned TAIL_CYCLES   = 40;   // extra wait after the final drain
  localparam logic [31:0] MOST_NEG      = 32'h8000_0000;
  localparam logic [31:0] MOST_POS      = 32'h7FFF_FFFF;

  // How the receiver paces out_tready during one phase.
  typedef enum logic [1:0] {
    RX_OPEN,    // always ready
    RX_COIN,    // ready on a fair coin each cycle
    RX_SPARSE,  // ready about one cycle in four
    RX_RUNS     // alternating runs of ready and stalled
  } rx_mode_t;

  // Shapes of random requests; most aim at the interesting corners of the span.
  typedef enum logic [2:0] {
    REQ_NARROW,  // span of 1 to 256 anywhere in the range
    REQ_ANY,     // both bounds fully random
    REQ_POINT,   // equal bounds
    REQ_WRAP,    // span wraps to zero
    REQ_POW2,    // span is a power of two
    REQ_WIDE     // span close to 2^32
  } req_shape_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata   = '0;   // [31:0] range_from, [63:32] range_to
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;         // [31:0] ranged_value, [63:32] raw_draw

  ranged_draw_scoreboard draws = new();

  // The sender bumps this to ask the receiver for one long hold-off.
  int unsigned hold_requests = 0;
  int unsigned holds_served  = 0;
  int unsigned directed_sent = 0;

  xorshift128_ranged_random dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Offer one request and hold it until the block takes it. The task is entered
  // and left at a rising edge, so in_tvalid stays high across back-to-back
  // transactions without ever being lowered and raised in the same step.
  task automatic send_range(logic [31:0] range_from, logic [31:0] range_to);
    in_tvalid <= 1'b1;
    in_tdata  <= {range_to, range_from};
    do begin
      @(posedge clk);
    end while (!in_tready);
    draws.note_request(range_from, range_to);
  endtask

  task automatic idle_cycles(int unsigned n);
    in_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Stop offering and wait until every owed result has been taken. At least
  // one edge always passes, so the next send_range never lands in this step.
  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    do begin
      @(posedge clk);
    end while (draws.pending() != 0);
  endtask

  // Directed corners: the wrapped full span in all its forms, equal bounds,
  // reversed bounds, extreme and alternating bit patterns.
  task automatic send_corners();
    send_range(MOST_NEG, MOST_POS);               // whole range, span wraps to zero
    send_range(32'd0, 32'hFFFF_FFFF);             // 0 up to -1 also wraps to zero
    send_range(32'd1, 32'd0);                     // reversed by one: span zero too
    send_range(MOST_POS, MOST_POS - 32'd1);
    send_range(32'd0, 32'd0);                     // equal bounds
    send_range(MOST_NEG, MOST_NEG);
    send_range(MOST_POS, MOST_POS);
    send_range(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_range(32'd0, 32'd1);
    send_range(-32'sd5, 32'sd5);
    send_range(32'd0, MOST_POS);
    send_range(MOST_NEG, 32'hFFFF_FFFF);
    send_range(MOST_NEG + 32'd1, MOST_POS);       // span of 2^32 - 1
    send_range(32'd0, -32'sd2);                   // reversed, span of 2^32 - 1
    send_range(MOST_POS, MOST_NEG);               // reversed, span of two
    send_range(32'sd10, -32'sd10);
    send_range(32'hFFFF_FFFF, 32'd0);
    send_range(32'h5555_5555, 32'hAAAA_AAAA);
    send_range(32'hAAAA_AAAA, 32'h5555_5555);
    send_range(32'd0, 32'h0000_FFFF);
    send_range(32'h1234_5678, 32'h1234_5678 + 32'd999);
    send_range(MOST_NEG, 32'd0);
    directed_sent = draws.noted;
  endtask

  // Build one random request as {range_to, range_from}.
  function automatic logic [63:0] random_range();
    logic [31:0] range_from;
    logic [31:0] range_to;
    int unsigned pick;
    req_shape_t  shape;
    pick       = $urandom_range(0, 99);
    range_from = $urandom;
    if (pick < 35)      shape = REQ_NARROW;
    else if (pick < 55) shape = REQ_ANY;
    else if (pick < 65) shape = REQ_POINT;
    else if (pick < 75) shape = REQ_WRAP;
    else if (pick < 85) shape = REQ_POW2;
    else                shape = REQ_WIDE;
    case (shape)
      REQ_NARROW: range_to = range_from + $urandom_range(0, 255);
      REQ_ANY:    range_to = $urandom;
      REQ_POINT:  range_to = range_from;
      REQ_WRAP:   range_to = range_from - 32'd1;
      REQ_POW2:   range_to = range_from + ((32'd1 << $urandom_range(0, 31)) - 32'd1);
      default:    range_to = range_from + (32'hFFFF_FFFE - $urandom_range(0, 255));
    endcase
    return {range_to, range_from};
  endfunction

  // Receiver: checks each accepted result, then picks the next out_tready.
  // Results are sampled at the edge before the block's own updates land, so
  // the check sees exactly what was presented during the handshake.
  rx_mode_t    rx_mode    = RX_OPEN;
  int unsigned phase_left = 0;
  int unsigned run_left   = 0;
  logic        run_level  = 1'b1;
  int unsigned hold_left  = 0;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      draws.check_result(out_tdata);
    end
    if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (hold_requests != holds_served) begin
      // Long hold-off: the output register and the modulo unit both fill, and
      // the block has to drop in_tready while the sender keeps offering.
      holds_served = hold_requests;
      hold_left    = LONG_HOLD - 1;
      out_tready <= 1'b0;
    end else begin
      if (phase_left == 0) begin
        rx_mode    = rx_mode_t'($urandom_range(0, 3));
        phase_left = $urandom_range(20, 200);
      end else begin
        phase_left--;
      end
      case (rx_mode)
        RX_OPEN:   out_tready <= 1'b1;
        RX_COIN:   out_tready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_tready <= ($urandom_range(0, 3) == 0);
        default: begin
          if (run_left == 0) begin
            run_level = ~run_level;
            run_left  = $urandom_range(1, 16);
          end
          run_left--;
          out_tready <= run_level;
        end
      endcase
    end
  end

  // Sender and sequencing of the whole run.
  initial begin
    int unsigned burst_left;
    int unsigned gap;
    logic [63:0] req;
    burst_left = 0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    send_corners();
    wait_for_drain();

    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 400) begin
        // Ask for the long output stall and keep a long burst going meanwhile.
        hold_requests <= hold_requests + 1;
        burst_left = 60;
      end
      if (n == 800 || n == 1300) begin
        wait_for_drain();
      end
      if (burst_left == 0) begin
        // Gaps from none at all up to beyond one full computation, so idle
        // stretches land on every phase of the request period.
        gap = $urandom_range(0, 40);
        if (gap != 0) idle_cycles(gap);
        burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req = random_range();
      send_range(req[31:0], req[63:32]);
    end

    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (draws.pending() != 0) begin
      draws.report_mismatch($sformatf("%0d results never arrived", draws.pending()));
    end

    $display("Covered %0d requests (%0d directed corners, %0d with a wrapped full span).",
             draws.noted, directed_sent, draws.full_spans);
    $display("Checked %0d results under bursty input, paced output and %0d long output stall.",
             draws.checked, holds_served);
    if (draws.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog: ends a run that hangs and reports it as a failure.
  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
